>>> design/rst_pkg.sv
// Package for the send tracker: sizes, command and result codes, shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rst_pkg;
   localparam int MAX_ENTRIES = 64;
   localparam int PAYLOAD_BYTES = 1024;
   localparam int MAX_PACKETS = 255;
   localparam int RESULT_LIMIT = 64;
   localparam int SLOT_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [47:0] TIMEOUT_AT_RESET = 48'd50000;

   typedef enum logic [1:0] {
      CMD_NEW = 2'd0, CMD_COMPLETE = 2'd1, CMD_RESEND = 2'd2, CMD_PROBE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_ACCEPTED = 3'd0, KIND_FULL = 3'd1, KIND_RETRANSMIT = 3'd2,
      KIND_BAD_INDEX = 3'd3, KIND_COMPLETED = 3'd4, KIND_PROBE = 3'd5
   } kind_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [31:0] message_id;
      logic [17:0] message_length;
      logic [15:0] port_number;
      logic [7:0]  packet_index;
      logic        index_valid;
      logic [47:0] now_time;
      logic [7:0]  count;
   } item_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [31:0] message_id;
      logic [17:0] length;
      logic [15:0] port;
      logic [7:0]  count_or_index;
      logic        last;
   } result_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_EXEC, ST_PROBE_RD, ST_PROBE_CHK, ST_EMIT
   } state_type;

   function automatic logic [7:0] packet_count(input logic [17:0] len);
      logic [18:0] c;
      c = (19'(len) + 19'(PAYLOAD_BYTES - 1)) / 19'(PAYLOAD_BYTES);
      packet_count = (c > 19'(MAX_PACKETS)) ? 8'(MAX_PACKETS) : c[7:0];
   endfunction
endpackage
`default_nettype wire

>>> design/rst_front.sv
// Front end of the send tracker: take request beats, work out packet counts
// and hold them in a short queue for the engine. Uses rst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rst_front import rst_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire item_type    req_item,
   output logic             item_valid,
   input  wire logic        item_ready,
   output item_type         item_out
);
   item_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push, pop;
   item_type cooked;

   always_comb begin
      cooked = req_item;
      cooked.count = packet_count(req_item.message_length);
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign item_valid = (cnt_ff != 2'd0);
   assign item_out = q_ff[rd_ff];
   assign push = req_valid && req_ready;
   assign pop = item_valid && item_ready;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   assign rd_in = rd_ff ^ pop;
   assign wr_in = wr_ff ^ push;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) q_ff[wr_ff] <= cooked;
   end
endmodule
`default_nettype wire

>>> design/rst_engine.sv
// Back end of the send tracker: entry table, age list and the sequencer that
// searches, updates and walks it. Uses rst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rst_engine import rst_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [47:0] probe_timeout,
   input  wire logic        item_valid,
   output logic             item_ready,
   input  wire item_type    item_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output result_type       rsp_out
);
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [63:0] key_mem [MAX_ENTRIES];
   logic [31:0] id_mem [MAX_ENTRIES];
   logic [17:0] len_mem [MAX_ENTRIES];
   logic [15:0] port_mem [MAX_ENTRIES];
   logic [47:0] stamp_mem [MAX_ENTRIES];
   logic [SLOT_W-1:0] prev_mem [MAX_ENTRIES];
   logic [SLOT_W-1:0] next_mem [MAX_ENTRIES];
   logic [SLOT_W-1:0] head_ff, head_in, tail_ff, tail_in;

   state_type state_ff, state_in;
   item_type it_ff, it_in;
   logic [SLOT_W:0] idx_ff, idx_in;
   logic found_ff, found_in, free_ok_ff, free_ok_in;
   logic [SLOT_W-1:0] hit_ff, hit_in, free_ff, free_in;
   logic [47:0] thr_ff, thr_in;
   logic [CNT_W-1:0] probed_ff, probed_in;
   result_type res_ff, res_in;
   result_type pend_ff, pend_in;
   logic res_v_ff, res_v_in;
   logic [SLOT_W-1:0] ph_ff;
   logic [47:0] ph_stamp_ff;
   logic [63:0] ph_key_ff;
   logic [31:0] ph_id_ff;
   logic [17:0] ph_len_ff;
   logic [15:0] ph_port_ff;
   logic [SLOT_W-1:0] ph_prev_ff, ph_next_ff;
   logic [63:0] rd_key_ff;
   logic [31:0] rd_id_ff;
   logic [17:0] rd_len_ff;
   logic [15:0] rd_port_ff;
   logic [SLOT_W-1:0] rd_prev_ff, rd_next_ff;
   logic [17:0] hlen_ff, hlen_in;
   logic [15:0] hport_ff, hport_in;
   logic [SLOT_W-1:0] hprev_ff, hprev_in, hnext_ff, hnext_in;
   logic [SLOT_W-1:0] mv_slot;
   logic mv_remove, mv_append, mv_stamp, wr_new, wr_lenport;
   logic [SLOT_W-1:0] p_s, n_s;
   logic is_head, is_tail, only_one, list_empty;
   logic [SLOT_W-1:0] slot_i;
   logic entry_hit;
   logic [17:0] hit_len;
   logic [15:0] hit_port;

   assign slot_i = idx_ff[SLOT_W-1:0];
   assign entry_hit = valid_ff[slot_i] && rd_key_ff == {it_ff.source_ip, it_ff.dest_ip}
                      && rd_id_ff == it_ff.message_id;
   assign list_empty = (valid_ff == '0);
   assign is_head = (head_ff == mv_slot);
   assign is_tail = (tail_ff == mv_slot);
   assign only_one = (valid_ff & ~(MAX_ENTRIES'(1) << mv_slot)) == '0;
   assign hit_len = hlen_ff;
   assign hit_port = hport_ff;

   assign item_ready = (state_ff == ST_IDLE);
   assign rsp_valid = res_v_ff;
   assign rsp_out = res_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (item_valid)
            state_in = (item_in.cmd == CMD_PROBE) ? ST_PROBE_RD : ST_SEARCH;
         ST_SEARCH: if (idx_ff == (SLOT_W+1)'(MAX_ENTRIES - 1) || entry_hit)
            state_in = ST_EXEC;
         ST_EXEC: if (!res_v_ff || rsp_ready) state_in = ST_IDLE;
         ST_PROBE_RD: state_in = ST_PROBE_CHK;
         ST_PROBE_CHK: if (!res_v_ff || rsp_ready) begin
            if (list_empty || ph_stamp_ff >= thr_ff
                || probed_ff == CNT_W'(RESULT_LIMIT) || probed_ff == CNT_W'(MAX_ENTRIES))
               state_in = ST_EMIT;
            else
               state_in = ST_PROBE_RD;
         end
         ST_EMIT: if (!res_v_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      it_in = it_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      hit_in = hit_ff;
      free_in = free_ff;
      free_ok_in = free_ok_ff;
      thr_in = thr_ff;
      probed_in = probed_ff;
      res_in = res_ff;
      pend_in = pend_ff;
      res_v_in = res_v_ff && !rsp_ready;
      valid_in = valid_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      hlen_in = hlen_ff;
      hport_in = hport_ff;
      hprev_in = hprev_ff;
      hnext_in = hnext_ff;
      mv_slot = hit_ff;
      p_s = hprev_ff;
      n_s = hnext_ff;
      mv_remove = 1'b0;
      mv_append = 1'b0;
      mv_stamp = 1'b0;
      wr_new = 1'b0;
      wr_lenport = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (item_valid) begin
            it_in = item_in;
            idx_in = '0;
            found_in = 1'b0;
            free_ok_in = 1'b0;
            probed_in = '0;
            thr_in = (item_in.now_time > probe_timeout) ? item_in.now_time - probe_timeout
                                                          : 48'd0;
         end
         ST_SEARCH: begin
            idx_in = idx_ff + 1'b1;
            if (entry_hit) begin
               found_in = 1'b1;
               hit_in = slot_i;
               hlen_in = rd_len_ff;
               hport_in = rd_port_ff;
               hprev_in = rd_prev_ff;
               hnext_in = rd_next_ff;
            end
            if (!valid_ff[slot_i] && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in = slot_i;
            end
         end
         ST_EXEC: if (!res_v_ff || rsp_ready) begin
            res_in.source_ip = it_ff.source_ip;
            res_in.dest_ip = it_ff.dest_ip;
            res_in.message_id = it_ff.message_id;
            res_in.last = 1'b1;
            res_in.length = hit_len;
            res_in.port = hit_port;
            res_in.count_or_index = 8'd0;
            res_in.kind = KIND_COMPLETED;
            unique case (it_ff.cmd)
               CMD_NEW: begin
                  res_in.length = it_ff.message_length;
                  res_in.port = it_ff.port_number;
                  res_in.count_or_index = it_ff.count;
                  res_v_in = 1'b1;
                  if (found_ff) begin
                     res_in.kind = KIND_ACCEPTED;
                     mv_remove = 1'b1;
                     mv_append = 1'b1;
                     mv_stamp = 1'b1;
                     wr_lenport = 1'b1;
                  end else if (free_ok_ff) begin
                     res_in.kind = KIND_ACCEPTED;
                     mv_slot = free_ff;
                     mv_append = 1'b1;
                     mv_stamp = 1'b1;
                     wr_new = 1'b1;
                     wr_lenport = 1'b1;
                  end else begin
                     res_in.kind = KIND_FULL;
                  end
               end
               CMD_COMPLETE: if (found_ff) begin
                  res_v_in = 1'b1;
                  mv_remove = 1'b1;
               end
               CMD_RESEND: if (found_ff) begin
                  mv_remove = 1'b1;
                  mv_append = 1'b1;
                  mv_stamp = 1'b1;
                  res_in.count_or_index = it_ff.packet_index;
                  res_in.kind = (it_ff.packet_index < packet_count(hit_len))
                                ? KIND_RETRANSMIT : KIND_BAD_INDEX;
                  res_v_in = it_ff.index_valid;
               end
               default: ;
            endcase
         end
         ST_PROBE_RD: ;
         ST_PROBE_CHK: if (!res_v_ff || rsp_ready) begin
            if (!(list_empty || ph_stamp_ff >= thr_ff
                || probed_ff == CNT_W'(RESULT_LIMIT) || probed_ff == CNT_W'(MAX_ENTRIES))) begin
               mv_slot = ph_ff;
               p_s = ph_prev_ff;
               n_s = ph_next_ff;
               mv_remove = 1'b1;
               mv_append = 1'b1;
               mv_stamp = 1'b1;
               probed_in = probed_ff + 1'b1;
               if (probed_ff != '0) begin
                  res_v_in = 1'b1;
                  res_in = pend_ff;
               end
               pend_in = '{KIND_PROBE, ph_key_ff[63:32], ph_key_ff[31:0], ph_id_ff,
                           ph_len_ff, ph_port_ff, 8'd0, 1'b0};
            end
         end
         ST_EMIT: if (!res_v_ff || rsp_ready) begin
            if (probed_ff != '0) begin
               res_v_in = 1'b1;
               res_in = pend_ff;
               res_in.last = 1'b1;
            end
         end
         default: ;
      endcase
      if (mv_remove && !mv_append) valid_in[mv_slot] = 1'b0;
      if (wr_new) valid_in[mv_slot] = 1'b1;
      if (mv_remove && mv_append) begin
         if (!is_tail) begin
            if (is_head) head_in = n_s;
            tail_in = mv_slot;
         end
      end else if (mv_remove) begin
         if (is_head) head_in = n_s;
         if (is_tail) tail_in = p_s;
      end else if (mv_append) begin
         if (list_empty) head_in = mv_slot;
         tail_in = mv_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         res_v_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         res_v_ff <= res_v_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
      it_ff <= it_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      hit_ff <= hit_in;
      free_ff <= free_in;
      free_ok_ff <= free_ok_in;
      thr_ff <= thr_in;
      probed_ff <= probed_in;
      res_ff <= res_in;
      pend_ff <= pend_in;
      hlen_ff <= hlen_in;
      hport_ff <= hport_in;
      hprev_ff <= hprev_in;
      hnext_ff <= hnext_in;
      rd_key_ff <= key_mem[idx_in[SLOT_W-1:0]];
      rd_id_ff <= id_mem[idx_in[SLOT_W-1:0]];
      rd_len_ff <= len_mem[idx_in[SLOT_W-1:0]];
      rd_port_ff <= port_mem[idx_in[SLOT_W-1:0]];
      rd_prev_ff <= prev_mem[idx_in[SLOT_W-1:0]];
      rd_next_ff <= next_mem[idx_in[SLOT_W-1:0]];
      ph_ff <= head_ff;
      ph_stamp_ff <= stamp_mem[head_ff];
      ph_key_ff <= key_mem[head_ff];
      ph_id_ff <= id_mem[head_ff];
      ph_len_ff <= len_mem[head_ff];
      ph_port_ff <= port_mem[head_ff];
      ph_prev_ff <= prev_mem[head_ff];
      ph_next_ff <= next_mem[head_ff];
      if (wr_new) begin
         key_mem[mv_slot] <= {it_ff.source_ip, it_ff.dest_ip};
         id_mem[mv_slot] <= it_ff.message_id;
      end
      if (wr_lenport) begin
         len_mem[mv_slot] <= it_ff.message_length;
         port_mem[mv_slot] <= it_ff.port_number;
      end
      if (mv_stamp) stamp_mem[mv_slot] <= it_ff.now_time;
      if (mv_remove && mv_append) begin
         if (!is_tail) begin
            if (!is_head) next_mem[p_s] <= n_s;
            prev_mem[n_s] <= is_head ? n_s : p_s;
            next_mem[tail_ff] <= mv_slot;
            prev_mem[mv_slot] <= tail_ff;
         end
      end else if (mv_remove) begin
         if (!is_head && !only_one) next_mem[p_s] <= n_s;
         if (!is_tail && !only_one) prev_mem[n_s] <= p_s;
      end else if (mv_append) begin
         if (!list_empty) next_mem[tail_ff] <= mv_slot;
         prev_mem[mv_slot] <= tail_ff;
      end
   end
endmodule
`default_nettype wire

>>> design/reliable_send_tracker.sv
// Top level of the send tracker: request front end, queue and table engine.
// Depends on rst_pkg, rst_front and rst_engine.
//
// Usage: req_* carries one command beat (new message, complete, resend, probe
// tick) with valid/ready; rsp_* returns result beats with valid/ready, the last
// result of a command flagged by rsp_last. Complete and resend commands that
// find no entry return nothing. csr_write_enable loads probe_timeout (50000
// after reset). A new, complete or resend beat scans the table one slot a
// cycle and stops early on a hit, so the sequential key search governs when
// its result comes. A probe tick checks the oldest entries in turn, moving
// each expired one to the tail with a result, up to RESULT_LIMIT per tick.
// The front queue holds two beats, so requests are taken while the engine is
// busy. One command is executed at a time.
// Reset (synchronous, active high) empties the table and the queue at once.
// When the receiver stalls, the result register holds and the engine waits;
// requests back up into the queue and then req_ready falls.
`timescale 1ns / 1ps
`default_nettype none
module reliable_send_tracker import rst_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [47:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_source_ip,
   input  wire logic [31:0] req_dest_ip,
   input  wire logic [31:0] req_message_id,
   input  wire logic [17:0] req_message_length,
   input  wire logic [15:0] req_port_number,
   input  wire logic [7:0]  req_packet_index,
   input  wire logic        req_index_valid,
   input  wire logic [47:0] req_now_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_out_source_ip,
   output logic [31:0]      rsp_out_dest_ip,
   output logic [31:0]      rsp_out_message_id,
   output logic [17:0]      rsp_out_length,
   output logic [15:0]      rsp_out_port,
   output logic [7:0]       rsp_out_count_or_index,
   output logic             rsp_last
);
   logic [47:0] timeout_ff;
   item_type req_item, q_item;
   logic q_valid, q_ready;
   result_type res;

   always_ff @(posedge clock) begin
      if (reset) timeout_ff <= TIMEOUT_AT_RESET;
      else if (csr_write_enable) timeout_ff <= csr_write_data;
   end

   assign req_item = '{cmd_type'(req_cmd), req_source_ip, req_dest_ip, req_message_id,
                       req_message_length, req_port_number, req_packet_index,
                       req_index_valid, req_now_time, 8'd0};

   rst_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_item,
      .item_valid(q_valid), .item_ready(q_ready), .item_out(q_item)
   );

   rst_engine u_engine (
      .clock, .reset, .probe_timeout(timeout_ff),
      .item_valid(q_valid), .item_ready(q_ready), .item_in(q_item),
      .rsp_valid, .rsp_ready, .rsp_out(res)
   );

   assign rsp_kind = res.kind;
   assign rsp_out_source_ip = res.source_ip;
   assign rsp_out_dest_ip = res.dest_ip;
   assign rsp_out_message_id = res.message_id;
   assign rsp_out_length = res.length;
   assign rsp_out_port = res.port;
   assign rsp_out_count_or_index = res.count_or_index;
   assign rsp_last = res.last;
endmodule
`default_nettype wire
